@@ sv/actcc_pkg.sv @@
// Shared types, character codes and limits of the ANSI text console controller.
package actcc_pkg;

  localparam int unsigned SEQ_BUF_DEPTH = 16;
  localparam int unsigned MAX_COLUMNS   = 256;
  localparam int unsigned MAX_ROWS      = 128;
  localparam int unsigned SEQ_W         = $clog2(SEQ_BUF_DEPTH + 1);

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_SGR      = 8'h6D;
  localparam logic [7:0] CH_CUP      = 8'h48;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7E;
  localparam logic [7:0] DIGIT_0     = 8'h30;
  localparam logic [7:0] DIGIT_9     = 8'h39;

  localparam logic [15:0] SGR_FG     = 16'd30;
  localparam logic [15:0] SGR_BG     = 16'd40;
  localparam logic [15:0] SGR_FG_HI  = 16'd90;
  localparam logic [15:0] SGR_BG_HI  = 16'd100;
  localparam logic [15:0] PARAM_MAX  = 16'hFFFF;
  localparam logic [3:0]  LEN_MAX    = 4'hF;
  localparam logic [3:0]  FG_DEFAULT = 4'hF;
  localparam logic [3:0]  BG_DEFAULT = 4'h0;

  localparam logic [8:0] COLUMNS_RST   = 9'd80;
  localparam logic [7:0] ROWS_RST      = 8'd25;
  localparam logic [7:0] SCROLL_RST    = 8'd1;
  localparam logic [7:0] MAX_GLYPH_RST = 8'd127;

  typedef enum logic [1:0] {
    CFG_COLUMNS,
    CFG_ROWS,
    CFG_SCROLL_LINES,
    CFG_MAX_GLYPH
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_CSI  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_GLYPH,
    OP_NEWLINE,
    OP_CSI_START,
    OP_PARAM,
    OP_SEMI,
    OP_SGR,
    OP_CUP
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       first;
  } tok_t;

  // Handshake between the parser front and the execution back.
  typedef struct packed {
    logic valid;
    tok_t tok;
  } tok_chan_t;

  typedef struct packed {
    logic [8:0] columns;
    logic [7:0] rows;
    logic [7:0] scroll_lines;
    logic [7:0] max_glyph;
  } cfg_t;

  typedef struct packed {
    logic       draw;
    logic [7:0] glyph;
    logic [7:0] col;
    logic [6:0] row;
    logic [3:0] fg;
    logic [3:0] bg;
    logic       scroll;
  } res_t;

endpackage

@@ sv/actcc_front.sv @@
// Byte classifier: tracks escape parsing mode and queues one token per byte.
module actcc_front import actcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] in_byte_i,
  output logic       full_o,
  output tok_chan_t  chan_o,
  input  logic       pop_i
);

  mode_e            mode_q, mode_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [SEQ_W-1:0] seq_next;
  tok_t             tok;

  tok_t       tq_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       acc;

  assign acc      = push_i && !full_o;
  assign full_o   = (cnt_q == 2'd2);
  assign seq_next = seq_q + SEQ_W'(1);

  // Next state of the parser.
  always_comb begin
    mode_d = mode_q;
    seq_d  = seq_q;
    case (mode_q)
      MODE_ESC: begin
        if (in_byte_i == CH_LBRACKET) begin
          mode_d = MODE_CSI;
          seq_d  = '0;
        end else begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_CSI: begin
        seq_d = seq_next;
        if (in_byte_i >= FINAL_LO && in_byte_i <= FINAL_HI) begin
          mode_d = MODE_IDLE;
        end else if (seq_next >= SEQ_W'(SEQ_BUF_DEPTH)) begin
          mode_d = MODE_IDLE;
        end
      end
      default: begin
        mode_d = (in_byte_i == CH_ESC) ? MODE_ESC : MODE_IDLE;
      end
    endcase
  end

  // Token for the byte in the current mode.
  always_comb begin
    tok.op    = OP_NONE;
    tok.data  = in_byte_i;
    tok.first = 1'b0;
    case (mode_q)
      MODE_ESC: begin
        if (in_byte_i == CH_LBRACKET) tok.op = OP_CSI_START;
      end
      MODE_CSI: begin
        tok.first = (seq_next == SEQ_W'(1));
        if (in_byte_i >= FINAL_LO && in_byte_i <= FINAL_HI) begin
          if (in_byte_i == CH_SGR)      tok.op = OP_SGR;
          else if (in_byte_i == CH_CUP) tok.op = OP_CUP;
        end else if (in_byte_i == CH_SEMI) begin
          tok.op = OP_SEMI;
        end else begin
          tok.op = OP_PARAM;
        end
      end
      default: begin
        if (in_byte_i == CH_LF)       tok.op = OP_NEWLINE;
        else if (in_byte_i != CH_ESC) tok.op = OP_GLYPH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      seq_q  <= '0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (acc) begin
        mode_q <= mode_d;
        seq_q  <= seq_d;
        wr_q   <= ~wr_q;
      end
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) tq_q[wr_q] <= tok;
  end

  assign chan_o.valid = (cnt_q != 2'd0);
  assign chan_o.tok   = tq_q[rd_q];

endmodule

@@ sv/actcc_back.sv @@
// Token executor: parameter shadow registers, colours, cursor and result queue.
module actcc_back import actcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  tok_chan_t chan_i,
  output logic      tok_pop_o,
  output logic      empty_o,
  output res_t      res_o,
  input  logic      pop_i
);

  logic [15:0] pv_q, pv_d;
  logic [3:0]  plen_q, plen_d;
  logic        pdig_q, pdig_d;
  logic [3:0]  pfg_q, pfg_d, pbg_q, pbg_d;
  logic [6:0]  prow_q, prow_d;
  logic [7:0]  pcol_q, pcol_d;
  logic        tgt_row_q, tgt_row_d;
  logic [3:0]  fore_q, fore_d, back_q, back_d;
  logic [7:0]  ccol_q, ccol_d;
  logic [6:0]  crow_q, crow_d;

  logic [8:0]  eff_cols;
  logic [7:0]  eff_rows, eff_scroll, scroll_raw;
  logic [6:0]  nl_row;
  logic        nl_scroll;
  logic [8:0]  col_inc;
  logic [7:0]  sgr_all;
  logic [15:0] cup_v;
  logic [7:0]  row_lim;
  logic [8:0]  col_lim;
  logic [6:0]  cup_row;
  logic [7:0]  cup_col;
  logic [19:0] acc_v;
  logic [3:0]  dval;
  tok_t        tok;
  res_t        res;

  res_t       rq_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       out_pop;

  function automatic logic [7:0] sgr_fn(logic [15:0] v, logic [3:0] len, logic dig,
                                        logic [3:0] fg, logic [3:0] bg);
    logic [3:0]  nf, nb;
    logic [15:0] t;
    nf = fg;
    nb = bg;
    if (len == 4'd0 || (len == 4'd1 && dig && v == 16'd0)) begin
      nf = FG_DEFAULT;
      nb = BG_DEFAULT;
    end else begin
      if (v >= SGR_FG && v <= SGR_FG + 16'd7) begin
        t  = v - SGR_FG;
        nf = t[3:0];
      end else if (v >= SGR_BG && v <= SGR_BG + 16'd7) begin
        t  = v - SGR_BG;
        nb = t[3:0];
      end
      if (v >= SGR_FG_HI && v <= SGR_FG_HI + 16'd7) begin
        t  = v - SGR_FG_HI + 16'd8;
        nf = t[3:0];
      end else if (v >= SGR_BG_HI && v <= SGR_BG_HI + 16'd7) begin
        t  = v - SGR_BG_HI + 16'd8;
        nb = t[3:0];
      end
    end
    return {nf, nb};
  endfunction

  assign tok       = chan_i.tok;
  assign tok_pop_o = chan_i.valid && (cnt_q != 2'd2);
  assign out_pop   = pop_i && !empty_o;

  // Screen geometry as the cursor logic sees it.
  always_comb begin
    if (cfg_i.columns == 9'd0)                  eff_cols = 9'd1;
    else if (cfg_i.columns > 9'(MAX_COLUMNS))   eff_cols = 9'(MAX_COLUMNS);
    else                                        eff_cols = cfg_i.columns;
    if (cfg_i.rows == 8'd0)                     eff_rows = 8'd1;
    else if (cfg_i.rows > 8'(MAX_ROWS))         eff_rows = 8'(MAX_ROWS);
    else                                        eff_rows = cfg_i.rows;
    scroll_raw = (cfg_i.scroll_lines == 8'd0) ? 8'd1 : cfg_i.scroll_lines;
    eff_scroll = (scroll_raw > eff_rows) ? eff_rows : scroll_raw;
  end

  always_comb begin
    logic [7:0] r;
    r         = eff_rows - eff_scroll;
    nl_scroll = ({1'b0, crow_q} + 8'd1) >= eff_rows;
    nl_row    = nl_scroll ? r[6:0] : crow_q + 7'd1;
  end

  assign col_inc = {1'b0, ccol_q} + 9'd1;
  assign sgr_all = sgr_fn(pv_q, plen_q, pdig_q, pfg_q, pbg_q);

  // CUP target, one-based and clamped to the screen.
  always_comb begin
    cup_v   = (pv_q == 16'd0) ? 16'd0 : pv_q - 16'd1;
    row_lim = eff_rows - 8'd1;
    col_lim = eff_cols - 9'd1;
    cup_row = (cup_v > {8'd0, row_lim}) ? row_lim[6:0] : cup_v[6:0];
    cup_col = (cup_v > {7'd0, col_lim}) ? col_lim[7:0] : cup_v[7:0];
  end

  always_comb begin
    dval  = tok.data[3:0] - DIGIT_0[3:0];
    acc_v = {1'b0, pv_q, 3'd0} + {3'd0, pv_q, 1'b0} + {16'd0, dval};
  end

  always_comb begin
    pv_d      = pv_q;
    plen_d    = plen_q;
    pdig_d    = pdig_q;
    pfg_d     = pfg_q;
    pbg_d     = pbg_q;
    prow_d    = prow_q;
    pcol_d    = pcol_q;
    tgt_row_d = tgt_row_q;
    fore_d    = fore_q;
    back_d    = back_q;
    ccol_d    = ccol_q;
    crow_d    = crow_q;
    res       = '0;
    case (tok.op)
      OP_GLYPH: begin
        res.draw  = 1'b1;
        res.glyph = (tok.data > cfg_i.max_glyph) ? CH_QMARK : tok.data;
        res.col   = ccol_q;
        res.row   = crow_q;
        if (col_inc >= eff_cols) begin
          ccol_d     = 8'd0;
          crow_d     = nl_row;
          res.scroll = nl_scroll;
        end else begin
          ccol_d = col_inc[7:0];
        end
      end
      OP_NEWLINE: begin
        ccol_d     = 8'd0;
        crow_d     = nl_row;
        res.scroll = nl_scroll;
      end
      OP_CSI_START: begin
        pv_d      = 16'd0;
        plen_d    = 4'd0;
        pdig_d    = 1'b1;
        tgt_row_d = 1'b1;
        pfg_d     = fore_q;
        pbg_d     = back_q;
        prow_d    = crow_q;
        pcol_d    = ccol_q;
      end
      OP_PARAM: begin
        if (pdig_q && tok.data >= DIGIT_0 && tok.data <= DIGIT_9) begin
          pv_d = (acc_v > {4'd0, PARAM_MAX}) ? PARAM_MAX : acc_v[15:0];
        end else begin
          pdig_d = 1'b0;
        end
        if (plen_q < LEN_MAX) plen_d = plen_q + 4'd1;
      end
      OP_SEMI: begin
        {pfg_d, pbg_d} = sgr_all;
        if (tgt_row_q) prow_d = cup_row;
        else           pcol_d = cup_col;
        tgt_row_d = ~tgt_row_q;
        pv_d      = 16'd0;
        plen_d    = 4'd0;
        pdig_d    = 1'b1;
      end
      OP_SGR: begin
        if (tok.first) begin
          pfg_d = FG_DEFAULT;
          pbg_d = BG_DEFAULT;
        end else if (plen_q != 4'd0) begin
          {pfg_d, pbg_d} = sgr_all;
        end
        fore_d = pfg_d;
        back_d = pbg_d;
      end
      OP_CUP: begin
        if (tgt_row_q) prow_d = cup_row;
        else           pcol_d = cup_col;
        tgt_row_d = ~tgt_row_q;
        crow_d    = prow_d;
        ccol_d    = pcol_d;
      end
      default: ;
    endcase
    res.fg = fore_d;
    res.bg = back_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q      <= 16'd0;
      plen_q    <= 4'd0;
      pdig_q    <= 1'b1;
      pfg_q     <= FG_DEFAULT;
      pbg_q     <= BG_DEFAULT;
      prow_q    <= 7'd0;
      pcol_q    <= 8'd0;
      tgt_row_q <= 1'b1;
      fore_q    <= FG_DEFAULT;
      back_q    <= BG_DEFAULT;
      ccol_q    <= 8'd0;
      crow_q    <= 7'd0;
      wr_q      <= 1'b0;
      rd_q      <= 1'b0;
      cnt_q     <= 2'd0;
    end else begin
      if (tok_pop_o) begin
        pv_q      <= pv_d;
        plen_q    <= plen_d;
        pdig_q    <= pdig_d;
        pfg_q     <= pfg_d;
        pbg_q     <= pbg_d;
        prow_q    <= prow_d;
        pcol_q    <= pcol_d;
        tgt_row_q <= tgt_row_d;
        fore_q    <= fore_d;
        back_q    <= back_d;
        ccol_q    <= ccol_d;
        crow_q    <= crow_d;
        wr_q      <= ~wr_q;
      end
      if (out_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, tok_pop_o} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_pop_o) rq_q[wr_q] <= res;
  end

  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = rq_q[rd_q];

endmodule

@@ sv/ansi_text_console_controller_unit.sv @@
// Top level of the ANSI text console controller: configuration registers, front and back.
//
//   channel   direction  handshake                 payload
//   input     in         push / full               in_byte_i
//   result    out        empty / pop               draw_valid_o .. scroll_valid_o
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte is accepted per cycle while full is low and gives exactly one result word;
// the execution stage retires one token per cycle while the result queue has room, which
// sets the rate. A byte reaches the result ports through the token queue and the result
// queue. Two-word queues between front and back and on the result side let either end
// stall without losing a word. Reset clears the parser, cursor, colours and queues.
module ansi_text_console_controller_unit import actcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       draw_valid_o,
  output logic [7:0] glyph_code_o,
  output logic [7:0] cell_col_o,
  output logic [6:0] cell_row_o,
  output logic [3:0] fg_index_o,
  output logic [3:0] bg_index_o,
  output logic       scroll_valid_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  cfg_t      cfg_q;
  tok_chan_t chan;
  logic      tok_pop;
  res_t      res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns      <= COLUMNS_RST;
      cfg_q.rows         <= ROWS_RST;
      cfg_q.scroll_lines <= SCROLL_RST;
      cfg_q.max_glyph    <= MAX_GLYPH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COLUMNS:      cfg_q.columns      <= cfg_data_i;
        CFG_ROWS:         cfg_q.rows         <= cfg_data_i[7:0];
        CFG_SCROLL_LINES: cfg_q.scroll_lines <= cfg_data_i[7:0];
        CFG_MAX_GLYPH:    cfg_q.max_glyph    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  actcc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_byte_i (in_byte_i),
    .full_o    (full),
    .chan_o    (chan),
    .pop_i     (tok_pop)
  );

  actcc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .chan_i    (chan),
    .tok_pop_o (tok_pop),
    .empty_o   (empty),
    .res_o     (res),
    .pop_i     (pop)
  );

  assign draw_valid_o   = res.draw;
  assign glyph_code_o   = res.glyph;
  assign cell_col_o     = res.col;
  assign cell_row_o     = res.row;
  assign fg_index_o     = res.fg;
  assign bg_index_o     = res.bg;
  assign scroll_valid_o = res.scroll;

endmodule

@@ sv/actcc_checker.sv @@
// Port-level checks of the console controller, bound to the top level.
module actcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       draw_valid_o,
  input logic [7:0] glyph_code_o,
  input logic [7:0] cell_col_o,
  input logic [6:0] cell_row_o,
  input logic [3:0] fg_index_o,
  input logic [3:0] bg_index_o,
  input logic       scroll_valid_o
);

  // Leaving reset, both queues are empty.
  a_reset_clear: assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("queues not empty after reset");

  // A word without a glyph carries no cell position or code.
  a_no_draw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !draw_valid_o) |-> (glyph_code_o == 8'd0 && cell_col_o == 8'd0
                                    && cell_row_o == 7'd0))
    else $error("non-drawing word carries cell data");

  // A waiting result word holds while it is not taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(draw_valid_o) && $stable(glyph_code_o)
                          && $stable(cell_col_o) && $stable(cell_row_o)
                          && $stable(fg_index_o) && $stable(bg_index_o)
                          && $stable(scroll_valid_o)))
    else $error("result word changed while stalled");

endmodule

bind ansi_text_console_controller_unit actcc_checker u_actcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .draw_valid_o   (draw_valid_o),
  .glyph_code_o   (glyph_code_o),
  .cell_col_o     (cell_col_o),
  .cell_row_o     (cell_row_o),
  .fg_index_o     (fg_index_o),
  .bg_index_o     (bg_index_o),
  .scroll_valid_o (scroll_valid_o)
);

@@ verif/testbench.sv @@
// Self-checking testbench for the ANSI text console controller unit.
module testbench;
  import actcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [7:0]  CH_BAD_ESC    = "X";
  localparam logic [7:0]  CH_ERASE_LINE = "K";

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] in_byte_i;
  logic       empty;
  logic       pop;
  logic       draw_valid_o;
  logic [7:0] glyph_code_o;
  logic [7:0] cell_col_o;
  logic [6:0] cell_row_o;
  logic [3:0] fg_index_o;
  logic [3:0] bg_index_o;
  logic       scroll_valid_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [8:0] cfg_data_i;

  ansi_text_console_controller_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_byte_i      (in_byte_i),
    .empty          (empty),
    .pop            (pop),
    .draw_valid_o   (draw_valid_o),
    .glyph_code_o   (glyph_code_o),
    .cell_col_o     (cell_col_o),
    .cell_row_o     (cell_row_o),
    .fg_index_o     (fg_index_o),
    .bg_index_o     (bg_index_o),
    .scroll_valid_o (scroll_valid_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Screen settings as the block sees them.
  int cfg_cols   = COLUMNS_RST;
  int cfg_rows   = ROWS_RST;
  int cfg_scroll = SCROLL_RST;
  int cfg_maxg   = MAX_GLYPH_RST;

  // Parser, colour and cursor state of the console.
  mode_e p_mode  = MODE_IDLE;
  int    seq_cnt = 0;
  int    pval    = 0;
  int    plen    = 0;
  bit    pdig    = 1'b1;
  int    pend_fg = FG_DEFAULT;
  int    pend_bg = BG_DEFAULT;
  int    pend_row = 0;
  int    pend_col = 0;
  bit    tgt_row = 1'b1;
  int    fg      = FG_DEFAULT;
  int    bg      = BG_DEFAULT;
  int    cur_col = 0;
  int    cur_row = 0;

  res_t  expected_cells[$];
  bit    idling = 1'b1;
  int    errors = 0;
  int    bytes_sent = 0;
  int    words_checked = 0;
  int    draws_seen = 0;
  int    scrolls_seen = 0;
  int    reg_writes = 0;
  int    cycle_count = 0;
  int    stall_left = 0;

  function automatic int screen_cols();
    if (cfg_cols == 0) return 1;
    return (cfg_cols > MAX_COLUMNS) ? MAX_COLUMNS : cfg_cols;
  endfunction

  function automatic int screen_rows();
    if (cfg_rows == 0) return 1;
    return (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
  endfunction

  function automatic void param_restart();
    pval = 0;
    plen = 0;
    pdig = 1'b1;
  endfunction

  function automatic void sgr_param_apply();
    if (plen == 0 || (plen == 1 && pdig && pval == 0)) begin
      pend_fg = FG_DEFAULT;
      pend_bg = BG_DEFAULT;
    end else begin
      if (pval >= SGR_FG && pval <= SGR_FG + 7) pend_fg = pval - SGR_FG;
      else if (pval >= SGR_BG && pval <= SGR_BG + 7) pend_bg = pval - SGR_BG;
      if (pval >= SGR_FG_HI && pval <= SGR_FG_HI + 7) pend_fg = pval - SGR_FG_HI + 8;
      else if (pval >= SGR_BG_HI && pval <= SGR_BG_HI + 7) pend_bg = pval - SGR_BG_HI + 8;
    end
  endfunction

  // Positions are 1-based on the wire; row and column alternate.
  function automatic void cup_param_apply();
    int v;
    int lim;
    v = (pval != 0) ? pval - 1 : 0;
    if (tgt_row) begin
      lim = screen_rows() - 1;
      pend_row = (v > lim) ? lim : v;
    end else begin
      lim = screen_cols() - 1;
      pend_col = (v > lim) ? lim : v;
    end
    tgt_row = ~tgt_row;
  endfunction

  function automatic bit advance_line();
    int r;
    int s;
    r = screen_rows();
    s = (cfg_scroll == 0) ? 1 : cfg_scroll;
    if (s > r) s = r;
    cur_col = 0;
    if (cur_row + 1 >= r) begin
      cur_row = r - s;
      return 1'b1;
    end
    cur_row = cur_row + 1;
    return 1'b0;
  endfunction

  function automatic res_t interpret_byte(logic [7:0] b);
    res_t r;
    int   v;
    r = '0;
    case (p_mode)
      MODE_ESC: begin
        if (b == CH_LBRACKET) begin
          p_mode = MODE_CSI;
          seq_cnt = 0;
          param_restart();
          tgt_row = 1'b1;
          pend_fg = fg;
          pend_bg = bg;
          pend_row = cur_row;
          pend_col = cur_col;
        end else begin
          p_mode = MODE_IDLE;
        end
      end
      MODE_CSI: begin
        seq_cnt = (seq_cnt + 1) & 'h7F;
        if (b >= FINAL_LO && b <= FINAL_HI) begin
          if (b == CH_SGR) begin
            if (seq_cnt == 1) begin
              pend_fg = FG_DEFAULT;
              pend_bg = BG_DEFAULT;
            end else if (plen != 0) begin
              sgr_param_apply();
            end
            fg = pend_fg & 'hF;
            bg = pend_bg & 'hF;
          end else if (b == CH_CUP) begin
            cup_param_apply();
            cur_row = pend_row & 'h7F;
            cur_col = pend_col & 'hFF;
          end
          p_mode = MODE_IDLE;
        end else begin
          if (b == CH_SEMI) begin
            sgr_param_apply();
            cup_param_apply();
            param_restart();
          end else begin
            if (pdig && b >= DIGIT_0 && b <= DIGIT_9) begin
              v = pval * 10 + (int'(b) - int'(DIGIT_0));
              pval = (v > PARAM_MAX) ? int'(PARAM_MAX) : v;
            end else begin
              pdig = 1'b0;
            end
            if (plen < LEN_MAX) plen++;
          end
          // The sequence buffer is full: the whole sequence is dropped.
          if (seq_cnt >= SEQ_BUF_DEPTH) p_mode = MODE_IDLE;
        end
      end
      default: begin
        p_mode = MODE_IDLE;
        if (b == CH_ESC) begin
          p_mode = MODE_ESC;
        end else if (b == CH_LF) begin
          r.scroll = advance_line();
        end else begin
          r.draw  = 1'b1;
          r.glyph = (int'(b) > cfg_maxg) ? CH_QMARK : b;
          r.col   = 8'(cur_col);
          r.row   = 7'(cur_row);
          cur_col = cur_col + 1;
          if (cur_col >= screen_cols()) r.scroll = advance_line();
        end
      end
    endcase
    r.fg = 4'(fg);
    r.bg = 4'(bg);
    return r;
  endfunction

  // Sends one byte; its result word is predicted now, since order alone decides it.
  task automatic send_byte(logic [7:0] b);
    @(negedge clk_i);
    if (idling && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    push      <= 1'b1;
    in_byte_i <= b;
    expected_cells.push_back(interpret_byte(b));
    bytes_sent++;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_decimal(int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_csi(string body, logic [7:0] fin);
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    for (int i = 0; i < body.len(); i++) send_byte(body[i]);
    send_byte(fin);
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, int val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 9'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_COLUMNS:      cfg_cols   = val & 'h1FF;
      CFG_ROWS:         cfg_rows   = val & 'hFF;
      CFG_SCROLL_LINES: cfg_scroll = val & 'hFF;
      default:          cfg_maxg   = val & 'hFF;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_screen(int cols, int nrows, int scroll, int maxg);
    wait_until_drained();
    write_register(CFG_COLUMNS, cols);
    write_register(CFG_ROWS, nrows);
    write_register(CFG_SCROLL_LINES, scroll);
    write_register(CFG_MAX_GLYPH, maxg);
  endtask

  function automatic int sgr_code_pick();
    case ($urandom_range(0, 6))
      0:       return 0;
      1:       return SGR_FG + $urandom_range(0, 7);
      2:       return SGR_BG + $urandom_range(0, 7);
      3:       return SGR_FG_HI + $urandom_range(0, 7);
      4:       return SGR_BG_HI + $urandom_range(0, 7);
      5:       return $urandom_range(0, 200);
      default: return $urandom_range(0, 99999);
    endcase
  endfunction

  task automatic send_param(bit cup);
    logic [7:0] junk;
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        // A stray byte inside the parameter ends digit accumulation unless it is a digit or semicolon.
        junk = 8'($urandom_range(0, 255));
        if (junk >= FINAL_LO && junk <= FINAL_HI) junk = junk ^ 8'h80;
        if ($urandom_range(0, 1) == 0) send_decimal($urandom_range(0, 120));
        send_byte(junk);
      end
      2: begin
        send_byte(DIGIT_0);
        send_byte(DIGIT_0);
      end
      default: begin
        if (!cup) send_decimal(sgr_code_pick());
        else if ($urandom_range(0, 3) == 0) send_decimal($urandom_range(0, 99999));
        else send_decimal($urandom_range(0, 260));
      end
    endcase
  endtask

  task automatic send_random_sequence();
    int kind;
    int n;
    bit cup;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        n = $urandom_range(1, 24);
        repeat (n) send_byte(($urandom_range(0, 9) == 0) ? CH_LF : 8'($urandom_range(0, 255)));
      end
      4, 5, 6, 7: begin
        cup = (kind >= 6);
        n = $urandom_range(0, 3);
        send_byte(CH_ESC);
        send_byte(CH_LBRACKET);
        for (int i = 0; i < n; i++) begin
          if (i != 0) send_byte(CH_SEMI);
          send_param(cup);
        end
        if ($urandom_range(0, 5) == 0) send_byte(CH_SEMI);
        send_byte(cup ? CH_CUP : CH_SGR);
      end
      8: begin
        // Malformed sequences: long bodies overflow, finals other than SGR and CUP are dropped.
        n = $urandom_range(0, 20);
        send_byte(CH_ESC);
        send_byte(CH_LBRACKET);
        repeat (n) send_byte(8'($urandom_range(0, 63)));
        if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(FINAL_LO, FINAL_HI)));
      end
      default: begin
        send_byte(CH_ESC);
        send_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic send_random_stream(int n);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) send_random_sequence();
  endtask

  task automatic test_directed_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_LF);
    send_byte(CH_ESC);
    send_byte(CH_BAD_ESC);
    send_csi("", CH_SGR);
    send_csi("97;41", CH_SGR);
    send_csi("70000", CH_CUP);
    send_csi("", CH_ERASE_LINE);
    send_csi("3;12", CH_CUP);
  endtask

  task automatic test_tiny_screen();
    set_screen(1, 1, 1, 0);
    send_random_stream(200);
  endtask

  task automatic test_largest_screen();
    set_screen(MAX_COLUMNS, MAX_ROWS, MAX_ROWS, 255);
    send_random_stream(300);
  endtask

  task automatic test_registers_out_of_range();
    // Zero sizes act as one; the cursor left over from the large screen is off it.
    set_screen(0, 0, 0, 64);
    send_random_stream(100);
    set_screen(300, 200, 200, 96);
    send_random_stream(100);
  endtask

  task automatic test_narrow_scrolling();
    set_screen(7, 5, 2, 127);
    send_random_stream(300);
  endtask

  task automatic test_back_to_back();
    set_screen(40, 12, 3, 126);
    idling = 1'b0;
    send_random_stream(350);
  endtask

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    in_byte_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_COLUMNS;
    cfg_data_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_bytes();
    test_tiny_screen();
    test_largest_screen();
    test_registers_out_of_range();
    test_narrow_scrolling();
    test_back_to_back();
    wait_until_drained();

    $display("Sent %0d bytes across %0d register writes; checked %0d result words.",
             bytes_sent, reg_writes, words_checked);
    $display("Cells drawn: %0d, scroll requests: %0d.", draws_seen, scrolls_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: pop with random stall bursts while idling is enabled.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t got;
    res_t want;
    if (rst_ni && pop && !empty) begin
      got = '{draw_valid_o, glyph_code_o, cell_col_o, cell_row_o,
              fg_index_o, bg_index_o, scroll_valid_o};
      if (expected_cells.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Result word with nothing expected: %p", got);
      end else begin
        want = expected_cells.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("Mismatch on word %0d: expected draw=%0b glyph=%02h col=%0d row=%0d",
                     words_checked, want.draw, want.glyph, want.col, want.row);
            $display("  expected fg=%0d bg=%0d scroll=%0b",
                     want.fg, want.bg, want.scroll);
            $display("  got draw=%0b glyph=%02h col=%0d row=%0d fg=%0d bg=%0d scroll=%0b",
                     got.draw, got.glyph, got.col, got.row, got.fg, got.bg, got.scroll);
          end
        end
        if (want.draw) draws_seen++;
        if (want.scroll) scrolls_seen++;
      end
      words_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding.",
               cycle_count, expected_cells.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
